FILE: hdl/cau_pkg.sv
// Shared types, constants and saturation helpers for the complex arithmetic unit.
package cau_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 12;
   // product width, quotient bits, divider datapath width, square-root datapath width
   localparam int PW = 2 * DATA_WIDTH;
   localparam int QB = DATA_WIDTH + 1;
   localparam int XW = ((FRAC_BITS > QB) ? FRAC_BITS : QB) + PW + 1;
   localparam int SW = PW + 2;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_MOD = 3'd4
   } op_type;

   typedef struct packed {
      logic [2:0]                    operation;
      logic signed [DATA_WIDTH-1:0]  a_real;
      logic signed [DATA_WIDTH-1:0]  a_imag;
      logic signed [DATA_WIDTH-1:0]  b_real;
      logic signed [DATA_WIDTH-1:0]  b_imag;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0]  res_real;
      logic signed [DATA_WIDTH-1:0]  res_imag;
      logic                          divide_by_zero;
      logic                          saturated;
   } rsp_type;

   // word travelling down the cell row
   typedef struct packed {
      logic [2:0]                    op;
      logic signed [DATA_WIDTH-1:0]  fast_re;
      logic signed [DATA_WIDTH-1:0]  fast_im;
      logic                          fast_sat;
      logic                          dz;
      logic                          neg_r;
      logic                          neg_i;
      logic                          ovf_r;
      logic                          ovf_i;
      logic [XW-1:0]                 rem_r;
      logic [XW-1:0]                 rem_i;
      logic [XW-1:0]                 dvs;
      logic [QB-1:0]                 quo_r;
      logic [QB-1:0]                 quo_i;
      logic [SW-1:0]                 rad;
      logic [SW-1:0]                 root;
      logic [SW-1:0]                 rbit;
   } cell_type;

   localparam logic signed [PW:0] WIDE_MAX =
      {{(PW - DATA_WIDTH + 2){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
   localparam logic signed [PW:0] WIDE_MIN =
      {{(PW - DATA_WIDTH + 2){1'b1}}, {(DATA_WIDTH - 1){1'b0}}};

   // returns {clipped, value}
   function automatic logic [DATA_WIDTH:0] clip_signed(input logic signed [PW:0] v);
      logic [DATA_WIDTH:0] r;
      if (v > WIDE_MAX) begin
         r = {1'b1, WIDE_MAX[DATA_WIDTH-1:0]};
      end else if (v < WIDE_MIN) begin
         r = {1'b1, WIDE_MIN[DATA_WIDTH-1:0]};
      end else begin
         r = {1'b0, v[DATA_WIDTH-1:0]};
      end
      return r;
   endfunction

   // sign/magnitude to saturated two's complement; big forces the clip
   function automatic logic [DATA_WIDTH:0] clip_mag(input logic neg, input logic big,
                                                    input logic [QB-1:0] mag);
      logic [QB-1:0] lim;
      logic [QB-1:0] m;
      logic [QB-1:0] m_n;
      logic          sat;
      lim = neg ? {2'b01, {(DATA_WIDTH - 1){1'b0}}} : {2'b00, {(DATA_WIDTH - 1){1'b1}}};
      sat = big || (mag > lim);
      m   = sat ? lim : mag;
      m_n = QB'(0) - m;
      return {sat, neg ? m_n[DATA_WIDTH-1:0] : m[DATA_WIDTH-1:0]};
   endfunction

endpackage

FILE: hdl/cau_front.sv
// Front end: operand products, sums, fast results and divider/root setup (three stages).
module cau_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cau_pkg::req_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output cau_pkg::cell_type out_data
);
   import cau_pkg::*;

   typedef struct packed {
      logic [2:0]                    op;
      logic signed [DATA_WIDTH-1:0]  ar;
      logic signed [DATA_WIDTH-1:0]  ai;
      logic signed [DATA_WIDTH-1:0]  br;
      logic signed [DATA_WIDTH-1:0]  bi;
      logic signed [PW-1:0]          p_rr;
      logic signed [PW-1:0]          p_ii;
      logic signed [PW-1:0]          p_ri;
      logic signed [PW-1:0]          p_ir;
      logic signed [PW-1:0]          p_aa_r;
      logic signed [PW-1:0]          p_aa_i;
      logic signed [PW-1:0]          p_bb_r;
      logic signed [PW-1:0]          p_bb_i;
   } prod_type;

   typedef struct packed {
      logic [2:0]                    op;
      logic signed [DATA_WIDTH-1:0]  fast_re;
      logic signed [DATA_WIDTH-1:0]  fast_im;
      logic                          fast_sat;
      logic signed [PW:0]            nr;
      logic signed [PW:0]            ni;
      logic [PW-1:0]                 den;
      logic [PW-1:0]                 rad;
   } sum_type;

   logic     a_valid_ff, b_valid_ff, c_valid_ff;
   logic     en_a, en_b, en_c;
   prod_type a_ff, a_in;
   sum_type  b_ff, b_in;
   cell_type c_ff, c_in;

   logic signed [PW:0]    t_re, t_im;
   logic [DATA_WIDTH:0]   k_re, k_im;
   logic [PW-1:0]         mag_r, mag_i;

   assign en_c     = !c_valid_ff || out_ready;
   assign en_b     = !b_valid_ff || en_c;
   assign en_a     = !a_valid_ff || en_b;
   assign in_ready = en_a;

   // stage A: all eight products in parallel
   always_comb begin
      a_in.op     = in_data.operation;
      a_in.ar     = in_data.a_real;
      a_in.ai     = in_data.a_imag;
      a_in.br     = in_data.b_real;
      a_in.bi     = in_data.b_imag;
      a_in.p_rr   = in_data.a_real * in_data.b_real;
      a_in.p_ii   = in_data.a_imag * in_data.b_imag;
      a_in.p_ri   = in_data.a_real * in_data.b_imag;
      a_in.p_ir   = in_data.a_imag * in_data.b_real;
      a_in.p_aa_r = in_data.a_real * in_data.a_real;
      a_in.p_aa_i = in_data.a_imag * in_data.a_imag;
      a_in.p_bb_r = in_data.b_real * in_data.b_real;
      a_in.p_bb_i = in_data.b_imag * in_data.b_imag;
   end

   // stage B: sums and the add/sub/mul results
   always_comb begin
      t_re = '0;
      t_im = '0;
      unique case (a_ff.op)
         OP_ADD: begin
            t_re = (PW+1)'(a_ff.ar) + (PW+1)'(a_ff.br);
            t_im = (PW+1)'(a_ff.ai) + (PW+1)'(a_ff.bi);
         end
         OP_SUB: begin
            t_re = (PW+1)'(a_ff.ar) - (PW+1)'(a_ff.br);
            t_im = (PW+1)'(a_ff.ai) - (PW+1)'(a_ff.bi);
         end
         OP_MUL: begin
            t_re = ((PW+1)'(a_ff.p_rr) - (PW+1)'(a_ff.p_ii)) >>> FRAC_BITS;
            t_im = ((PW+1)'(a_ff.p_ri) + (PW+1)'(a_ff.p_ir)) >>> FRAC_BITS;
         end
         default: begin
            t_re = '0;
            t_im = '0;
         end
      endcase
      k_re = clip_signed(t_re);
      k_im = clip_signed(t_im);
      b_in.op       = a_ff.op;
      b_in.fast_re  = k_re[DATA_WIDTH-1:0];
      b_in.fast_im  = k_im[DATA_WIDTH-1:0];
      b_in.fast_sat = k_re[DATA_WIDTH] | k_im[DATA_WIDTH];
      b_in.nr       = (PW+1)'(a_ff.p_rr) + (PW+1)'(a_ff.p_ii);
      b_in.ni       = (PW+1)'(a_ff.p_ir) - (PW+1)'(a_ff.p_ri);
      b_in.den      = $unsigned(a_ff.p_bb_r) + $unsigned(a_ff.p_bb_i);
      b_in.rad      = $unsigned(a_ff.p_aa_r) + $unsigned(a_ff.p_aa_i);
   end

   // stage C: magnitudes, range check and initial divisor/root words
   always_comb begin
      mag_r = b_ff.nr[PW] ? PW'(-b_ff.nr) : PW'(b_ff.nr);
      mag_i = b_ff.ni[PW] ? PW'(-b_ff.ni) : PW'(b_ff.ni);
      c_in.op       = b_ff.op;
      c_in.fast_re  = b_ff.fast_re;
      c_in.fast_im  = b_ff.fast_im;
      c_in.fast_sat = b_ff.fast_sat;
      c_in.dz       = (b_ff.op == OP_DIV) && (b_ff.den == '0);
      c_in.neg_r    = b_ff.nr[PW];
      c_in.neg_i    = b_ff.ni[PW];
      c_in.rem_r    = XW'(mag_r) << FRAC_BITS;
      c_in.rem_i    = XW'(mag_i) << FRAC_BITS;
      c_in.ovf_r    = c_in.rem_r >= (XW'(b_ff.den) << QB);
      c_in.ovf_i    = c_in.rem_i >= (XW'(b_ff.den) << QB);
      c_in.dvs      = XW'(b_ff.den) << (QB - 1);
      c_in.quo_r    = '0;
      c_in.quo_i    = '0;
      c_in.rad      = SW'(b_ff.rad);
      c_in.root     = '0;
      c_in.rbit     = SW'(1) << PW;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (en_a) a_valid_ff <= in_valid;
         if (en_b) b_valid_ff <= a_valid_ff;
         if (en_c) c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) a_ff <= a_in;
      if (en_b) b_ff <= b_in;
      if (en_c) c_ff <= c_in;
   end

   assign out_valid = c_valid_ff;
   assign out_data  = c_ff;

endmodule

FILE: hdl/cau_cell.sv
// One cell of the row: a restoring divide step on both parts and one square-root step.
module cau_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cau_pkg::cell_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output cau_pkg::cell_type out_data
);
   import cau_pkg::*;

   logic          valid_ff;
   logic          en;
   cell_type      data_ff, data_in;
   logic [SW-1:0] trial;

   assign en       = !valid_ff || out_ready;
   assign in_ready = en;

   always_comb begin
      data_in = in_data;
      trial   = in_data.root + in_data.rbit;
      if (in_data.rem_r >= in_data.dvs) begin
         data_in.rem_r = in_data.rem_r - in_data.dvs;
         data_in.quo_r = {in_data.quo_r[QB-2:0], 1'b1};
      end else begin
         data_in.quo_r = {in_data.quo_r[QB-2:0], 1'b0};
      end
      if (in_data.rem_i >= in_data.dvs) begin
         data_in.rem_i = in_data.rem_i - in_data.dvs;
         data_in.quo_i = {in_data.quo_i[QB-2:0], 1'b1};
      end else begin
         data_in.quo_i = {in_data.quo_i[QB-2:0], 1'b0};
      end
      data_in.dvs = in_data.dvs >> 1;
      if (in_data.rad >= trial) begin
         data_in.rad  = in_data.rad - trial;
         data_in.root = (in_data.root >> 1) + in_data.rbit;
      end else begin
         data_in.root = in_data.root >> 1;
      end
      data_in.rbit = in_data.rbit >> 2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: hdl/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: front end, cell row and result register.
// Takes one word per clock while not stalled and returns one result word per input word, in
// order, through three front-end stages (products, sums, divider/root setup), a row of
// DATA_WIDTH+1 cells that each retire one quotient bit of both divide parts and one
// square-root step, and the result register. Every stage holds its word under stall and
// empty stages fill up, so input keeps flowing while a result waits at rsp_valid.
// Add and subtract are exact, multiply scales with floor, divide truncates toward zero,
// and modulus is the integer square root of a_real^2 + a_imag^2; all parts saturate to
// the signed range and raise saturated. A divide by zero returns zero with
// divide_by_zero set; unused operation codes return all zero.
module complex_arithmetic_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cau_pkg::rsp_type rsp_data
);
   import cau_pkg::*;

   // chain[0] is the front end output, chain[QB] the last cell's
   cell_type chain_data [QB+1];
   logic     chain_valid [QB+1];
   logic     chain_ready [QB+1];

   logic     rsp_valid_ff;
   rsp_type  rsp_data_ff, rsp_data_in;
   logic     en_out;
   cell_type tail;

   logic [DATA_WIDTH:0] k_re, k_im;

   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   for (genvar k = 0; k < QB; k++) begin : g_cell
      cau_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_data   (chain_data[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_data  (chain_data[k+1])
      );
   end

   assign tail            = chain_data[QB];
   assign en_out          = !rsp_valid_ff || rsp_ready;
   assign chain_ready[QB] = en_out;

   // final select and saturation of the divide and modulus results
   always_comb begin
      rsp_data_in = '0;
      k_re        = '0;
      k_im        = '0;
      unique case (tail.op)
         OP_ADD, OP_SUB, OP_MUL: begin
            rsp_data_in.res_real  = tail.fast_re;
            rsp_data_in.res_imag  = tail.fast_im;
            rsp_data_in.saturated = tail.fast_sat;
         end
         OP_DIV: begin
            if (tail.dz) begin
               rsp_data_in.divide_by_zero = 1'b1;
            end else begin
               k_re = clip_mag(tail.neg_r, tail.ovf_r, tail.quo_r);
               k_im = clip_mag(tail.neg_i, tail.ovf_i, tail.quo_i);
               rsp_data_in.res_real  = k_re[DATA_WIDTH-1:0];
               rsp_data_in.res_imag  = k_im[DATA_WIDTH-1:0];
               rsp_data_in.saturated = k_re[DATA_WIDTH] | k_im[DATA_WIDTH];
            end
         end
         OP_MOD: begin
            // root stays below 2^DATA_WIDTH, so QB bits hold it
            k_re = clip_mag(1'b0, 1'b0, tail.root[QB-1:0]);
            rsp_data_in.res_real  = k_re[DATA_WIDTH-1:0];
            rsp_data_in.saturated = k_re[DATA_WIDTH];
         end
         default: begin
            rsp_data_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= chain_valid[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // divide-by-zero word carries zero parts and no clip
   a_dz_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_by_zero |->
         rsp_data.res_real == '0 && rsp_data.res_imag == '0 && !rsp_data.saturated)
      else $error("divide-by-zero result not clean");

   // the zero-divisor mark only ever travels with a divide
   a_dz_op: assert property (@(posedge clock) disable iff (reset)
      chain_valid[QB] && tail.dz |-> tail.op == OP_DIV)
      else $error("divide-by-zero mark on non-divide word");

   // pipeline is empty right after reset, so input is open
   a_ready_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> req_ready)
      else $error("input not ready after reset");

endmodule

FILE: test/cau_checker.sv
// Checker for the complex arithmetic unit: watches both channels, predicts and compares.
module cau_checker
   import cau_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   rsp_type expected_words[$];
   int mismatch_count;

   // saturate a wide signed value, returns value and clip flag
   function automatic void sat16(input longint v, output logic [15:0] q, inout logic clipped);
      if (v > 32767) begin
         q = 16'sd32767;
         clipped = 1'b1;
      end else if (v < -32768) begin
         q = 16'h8000;
         clipped = 1'b1;
      end else begin
         q = v[15:0];
      end
   endfunction

   // floor of v / 2^FRAC_BITS
   function automatic longint floor_scale(input longint v);
      return v >>> FRAC_BITS;
   endfunction

   // (num * 2^FRAC_BITS) / den, toward zero; capped well past the clip bound
   function automatic longint div_trunc(input longint num, input longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = mag / den;
      if (q > 32768) q = 32769;
      else q = (mag * (64'sd1 <<< FRAC_BITS)) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint int_sqrt(input longint n);
      longint r;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         if ((r + (64'sd1 <<< b)) * (r + (64'sd1 <<< b)) <= n) r = r + (64'sd1 <<< b);
      end
      return r;
   endfunction

   function automatic rsp_type predict_result(input req_type w);
      rsp_type r;
      longint ar, ai, br, bi, den;
      logic clipped;
      ar = w.a_real;
      ai = w.a_imag;
      br = w.b_real;
      bi = w.b_imag;
      r = '0;
      clipped = 1'b0;
      case (w.operation)
         OP_ADD: begin
            sat16(ar + br, r.res_real, clipped);
            sat16(ai + bi, r.res_imag, clipped);
         end
         OP_SUB: begin
            sat16(ar - br, r.res_real, clipped);
            sat16(ai - bi, r.res_imag, clipped);
         end
         OP_MUL: begin
            sat16(floor_scale(ar * br - ai * bi), r.res_real, clipped);
            sat16(floor_scale(ar * bi + ai * br), r.res_imag, clipped);
         end
         OP_DIV: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               r.divide_by_zero = 1'b1;
            end else begin
               sat16(div_trunc(ar * br + ai * bi, den), r.res_real, clipped);
               sat16(div_trunc(ai * br - ar * bi, den), r.res_imag, clipped);
            end
         end
         OP_MOD: begin
            sat16(int_sqrt(ar * ar + ai * ai), r.res_real, clipped);
         end
         default: ;
      endcase
      r.saturated = clipped;
      return r;
   endfunction

   assign pending = expected_words.size();
   assign fail_count = mismatch_count;

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_words.delete();
         mismatch_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               if (mismatch_count < 10) $display("unexpected result word %h", rsp_data);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_words.pop_front();
               if (rsp_data !== want) begin
                  if (mismatch_count < 10)
                     $display("mismatch: re %0d/%0d im %0d/%0d dz %b/%b sat %b/%b (exp/got)",
                              want.res_real, rsp_data.res_real,
                              want.res_imag, rsp_data.res_imag,
                              want.divide_by_zero, rsp_data.divide_by_zero,
                              want.saturated, rsp_data.saturated);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_valid && req_ready) expected_words.push_back(predict_result(req_data));
      end
   end
endmodule

FILE: test/tb.sv
// Testbench top: drives the complex arithmetic unit and gives the verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cau_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      idle_cycles = 0;
   logic    hold_req = 1'b0;   // asks the receiver for its long stall
   int      hold_count = 80;   // cycles left in the long receiver stall
   int      rx_wait = 0;       // cycles left before the receiver takes again
   int      rx_gap;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   complex_arithmetic_unit dut (.*);

   cau_checker checker_i (.*);

   // extreme and random operand values for the random part
   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'(16'sd4096);
         4: return 16'($urandom_range(0, 31) - 16);
         default: return 16'($urandom);
      endcase
   endfunction

   // hand one word to the block, waiting the drawn gap first
   task automatic send_word(input req_type w, input bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering and wait until every expected result has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
   endtask

   function automatic req_type make_word(input logic [2:0] op, input logic [15:0] ar,
                                         input logic [15:0] ai, input logic [15:0] br,
                                         input logic [15:0] bi);
      req_type w;
      w.operation = op;
      w.a_real = ar;
      w.a_imag = ai;
      w.b_real = br;
      w.b_imag = bi;
      return w;
   endfunction

   // receiver: a drawn gap after each word, plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         rx_wait    <= 0;
         hold_count <= 80;
      end else if (hold_req && hold_count > 0) begin
         rsp_ready  <= 1'b0;
         hold_count <= hold_count - 1;
      end else if (rsp_ready && rsp_valid) begin
         rx_gap = $urandom_range(0, 11);
         rsp_ready <= (rx_gap == 0);
         rx_wait   <= (rx_gap == 0) ? 0 : rx_gap - 1;
      end else if (rx_wait > 0) begin
         rx_wait <= rx_wait - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      req_type w;
      bit burst;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes of every operation, zero divisor, unused codes
      send_word(make_word(OP_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000), 0);
      send_word(make_word(OP_ADD, 16'h0001, 16'hffff, 16'hfffe, 16'h0002), 0);
      send_word(make_word(OP_SUB, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff), 0);
      send_word(make_word(OP_SUB, 16'h8000, 16'h0000, 16'h0001, 16'h0000), 0);
      send_word(make_word(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000), 0);
      send_word(make_word(OP_MUL, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff), 0);
      send_word(make_word(OP_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000), 0);
      send_word(make_word(OP_DIV, 16'h1000, 16'h0000, 16'h0000, 16'h0000), 0);
      send_word(make_word(OP_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000), 0);
      send_word(make_word(OP_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000), 0);
      send_word(make_word(OP_DIV, 16'hffff, 16'h0001, 16'h7fff, 16'h8000), 0);
      send_word(make_word(OP_DIV, 16'h0000, 16'h0000, 16'h0003, 16'hfffd), 0);
      send_word(make_word(OP_MOD, 16'h8000, 16'h8000, 16'h0000, 16'h0000), 0);
      send_word(make_word(OP_MOD, 16'h7fff, 16'h0000, 16'h0000, 16'h0000), 0);
      send_word(make_word(OP_MOD, 16'h0003, 16'hfffc, 16'h1234, 16'h0000), 0);
      send_word(make_word(3'd5, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff), 0);
      send_word(make_word(3'd6, 16'h8000, 16'h8000, 16'h0000, 16'h0000), 0);
      send_word(make_word(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff), 0);

      // sender pause: let every expected result drain
      drain();

      for (int n = 0; n < 850; n++) begin
         // around item 300, stall the receiver long enough to back up the pipe
         if (n == 300) hold_req <= 1'b1;
         burst = (n >= 300 && n < 360) || (n % 97 < 20);
         w.operation = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                     : 3'($urandom_range(0, 4));
         w.a_real = pick_value();
         w.a_imag = pick_value();
         w.b_real = pick_value();
         w.b_imag = pick_value();
         if (w.operation == OP_DIV && $urandom_range(0, 9) == 0) begin
            w.b_real = '0;
            w.b_imag = '0;
         end
         send_word(w, burst);
         if (n == 600) drain();
      end

      drain();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && !rsp_valid) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
